### src/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg - shared types for the slot readiness scoreboard
// Event kind codes and the state snapshot carried from scoreboard to output.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int unsigned MASK_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned KIND_W  = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_READY       = 4'd0,
      KIND_SUBMITTED   = 4'd1,
      KIND_PROMOTED    = 4'd2,
      KIND_COMPLETE    = 4'd3,
      KIND_CONSUMED    = 4'd4,
      KIND_PREPARED    = 4'd5,
      KIND_FAILED      = 4'd6,
      KIND_INVALIDATED = 4'd7,
      KIND_CLEANUP     = 4'd8
   } kind_code_type;

   typedef enum logic {
      REQ_EVENT    = 1'b0,
      REQ_BOUNDARY = 1'b1
   } req_code_type;

   typedef struct packed {
      logic [MASK_W-1:0]  dirty;
      logic [MASK_W-1:0]  ready;
      logic [MASK_W-1:0]  failed;
      logic [MASK_W-1:0]  invalidated;
      logic [MASK_W-1:0]  attention;
      logic [COUNT_W-1:0] spill;
      logic [COUNT_W-1:0] duplicate;
      logic [COUNT_W-1:0] generation;
   } snapshot_type;

endpackage

### src/slot_readiness_scoreboard.sv
// ----------------------------------------------------------------------------
// slot_readiness_scoreboard - per-slot status masks and event counters
// The snapshot of a transfer is registered in the result register, or in the skid entry while that is stalled.
// Throughput: one request per cycle while req_stall is low; the next state is combinational from the state register.
// A result register and one skid entry decouple the two sides.
// Reset (synchronous): all masks and counters zero, no result pending.
// ----------------------------------------------------------------------------
module slot_readiness_scoreboard #(
   parameter int unsigned NUM_SLOTS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic                         req_from_slot_source,
   input  logic [srs_pkg::KIND_W-1:0]   req_kind,
   input  logic [srs_pkg::SLOT_W-1:0]   req_slot_number,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [srs_pkg::MASK_W-1:0]   rsp_dirty_mask,
   output logic [srs_pkg::MASK_W-1:0]   rsp_ready_mask,
   output logic [srs_pkg::MASK_W-1:0]   rsp_failed_mask,
   output logic [srs_pkg::MASK_W-1:0]   rsp_invalidated_mask,
   output logic [srs_pkg::MASK_W-1:0]   rsp_attention_mask,
   output logic [srs_pkg::COUNT_W-1:0]  rsp_spill_count,
   output logic [srs_pkg::COUNT_W-1:0]  rsp_duplicate_ready_count,
   output logic [srs_pkg::COUNT_W-1:0]  rsp_clear_epoch
);
   import srs_pkg::*;

   snapshot_type state_ff, state_in;
   snapshot_type rsp_data;
   logic         buf_full;
   logic         req_xfer;

   // Accept a request whenever the skid entry is free; the result register
   // may still hold an earlier snapshot waiting on rsp_stall.
   assign req_stall = buf_full;
   assign req_xfer  = req_valid & ~buf_full;

   // Next state for the presented request; commit only on a transfer.
   srs_event_logic #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_event_logic (
      .req_type         (req_type),
      .from_slot_source (req_from_slot_source),
      .kind             (req_kind),
      .slot_number      (req_slot_number),
      .state_cur        (state_ff),
      .state_nxt        (state_in)
   );

   // Scoreboard state: advance on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // The post-update snapshot goes straight into the result buffer, so the
   // response matches the state right after its own request.
   srs_result_buffer u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_xfer),
      .load_data  (state_in),
      .full       (buf_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

   assign rsp_dirty_mask            = rsp_data.dirty;
   assign rsp_ready_mask            = rsp_data.ready;
   assign rsp_failed_mask           = rsp_data.failed;
   assign rsp_invalidated_mask      = rsp_data.invalidated;
   assign rsp_attention_mask        = rsp_data.attention;
   assign rsp_spill_count           = rsp_data.spill;
   assign rsp_duplicate_ready_count = rsp_data.duplicate;
   assign rsp_clear_epoch           = rsp_data.generation;

endmodule

### src/srs_event_logic.sv
// ----------------------------------------------------------------------------
// srs_event_logic - next-state logic of the scoreboard
// Applies one slot event or boundary clear to the current state.
// ----------------------------------------------------------------------------
module srs_event_logic #(
   parameter int unsigned NUM_SLOTS = 32
) (
   input  logic                        req_type,
   input  logic                        from_slot_source,
   input  logic [srs_pkg::KIND_W-1:0]  kind,
   input  logic [srs_pkg::SLOT_W-1:0]  slot_number,
   input  srs_pkg::snapshot_type       state_cur,
   output srs_pkg::snapshot_type       state_nxt
);
   import srs_pkg::*;

   logic [MASK_W-1:0] hit;
   logic              in_range;
   logic [MASK_W-1:0] ready_clr;

   // one-hot decode, limited to the implemented slots
   always_comb begin
      hit = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit[i] = (slot_number == SLOT_W'(i));
      end
   end

   assign in_range  = (slot_number < SLOT_W'(NUM_SLOTS));
   assign ready_clr = state_cur.ready & ~hit;

   always_comb begin
      state_nxt = state_cur;
      if (req_code_type'(req_type) == REQ_BOUNDARY) begin
         state_nxt.generation  = state_cur.generation + COUNT_W'(1);
         state_nxt.dirty       = '0;
         state_nxt.ready       = '0;
         state_nxt.failed      = '0;
         state_nxt.invalidated = '0;
         state_nxt.attention   = '0;
      end else if (from_slot_source) begin
         if (!in_range) begin
            state_nxt.spill = state_cur.spill + COUNT_W'(1);
         end else begin
            state_nxt.dirty = state_cur.dirty | hit;
            unique case (kind_code_type'(kind))
               KIND_READY: begin
                  if ((state_cur.ready & hit) != '0) begin
                     state_nxt.duplicate = state_cur.duplicate + COUNT_W'(1);
                  end
                  state_nxt.ready     = state_cur.ready | hit;
                  state_nxt.attention = state_cur.attention | hit;
               end
               KIND_SUBMITTED, KIND_PROMOTED, KIND_COMPLETE,
               KIND_CONSUMED, KIND_PREPARED: begin
                  state_nxt.ready     = ready_clr;
                  state_nxt.attention = ready_clr | state_cur.failed
                                      | state_cur.invalidated;
               end
               KIND_FAILED: begin
                  state_nxt.ready     = ready_clr;
                  state_nxt.failed    = state_cur.failed | hit;
                  state_nxt.attention = state_cur.attention | hit;
               end
               KIND_INVALIDATED: begin
                  state_nxt.ready       = ready_clr;
                  state_nxt.invalidated = state_cur.invalidated | hit;
                  state_nxt.attention   = state_cur.attention | hit;
               end
               KIND_CLEANUP: begin
                  state_nxt.ready       = ready_clr;
                  state_nxt.failed      = state_cur.failed & ~hit;
                  state_nxt.invalidated = state_cur.invalidated & ~hit;
                  state_nxt.attention   = ready_clr
                                        | (state_cur.failed & ~hit)
                                        | (state_cur.invalidated & ~hit);
               end
               default: begin
                  // unassigned kinds only mark the slot dirty
               end
            endcase
         end
      end
   end

endmodule

### src/srs_result_buffer.sv
// ----------------------------------------------------------------------------
// srs_result_buffer - result register with one skid entry
// Holds snapshots in order while the result side stalls.
// ----------------------------------------------------------------------------
module srs_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  srs_pkg::snapshot_type load_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output srs_pkg::snapshot_type out_data
);
   import srs_pkg::*;

   logic         out_valid_ff, out_valid_in;
   snapshot_type out_data_ff,  out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   snapshot_type skid_data_ff,  skid_data_in;
   logic         take;

   assign take = out_valid_ff & ~out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no load while the skid is occupied
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = load_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = load_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### src/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker - port-level checks for the slot readiness scoreboard
// Mask consistency of every response and hold behavior under stall.
// ----------------------------------------------------------------------------
module srs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [srs_pkg::MASK_W-1:0]   rsp_dirty_mask,
   input logic [srs_pkg::MASK_W-1:0]   rsp_ready_mask,
   input logic [srs_pkg::MASK_W-1:0]   rsp_failed_mask,
   input logic [srs_pkg::MASK_W-1:0]   rsp_invalidated_mask,
   input logic [srs_pkg::MASK_W-1:0]   rsp_attention_mask,
   input logic [srs_pkg::COUNT_W-1:0]  rsp_spill_count,
   input logic [srs_pkg::COUNT_W-1:0]  rsp_duplicate_ready_count,
   input logic [srs_pkg::COUNT_W-1:0]  rsp_clear_epoch
);
   import srs_pkg::*;

   // attention is always the union of ready, failed and invalidated
   a_attention_union: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_attention_mask ==
                     (rsp_ready_mask | rsp_failed_mask | rsp_invalidated_mask)))
      else $error("attention mask is not ready|failed|invalidated");

   // a slot can only carry status if it was touched since the last clear
   a_status_dirty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_ready_mask | rsp_failed_mask | rsp_invalidated_mask)
                      & ~rsp_dirty_mask) == '0))
      else $error("status bit set on a slot that is not dirty");

   // the request side only stalls while a response is pending
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_clear_epoch)
                                   && $stable(rsp_spill_count)
                                   && $stable(rsp_duplicate_ready_count)
                                   && $stable(rsp_dirty_mask)
                                   && $stable(rsp_ready_mask)
                                   && $stable(rsp_failed_mask)
                                   && $stable(rsp_invalidated_mask)
                                   && $stable(rsp_attention_mask)))
      else $error("stalled response dropped or changed");

endmodule

bind slot_readiness_scoreboard srs_checker u_srs_checker (.*);
